### rtl/pda_pkg.sv
package pda_pkg;

  // Window geometry and derived widths
  localparam int WINDOW_DEPTH = 16;
  localparam int SAMPLE_W     = 16;
  localparam int PTR_W        = $clog2(WINDOW_DEPTH);
  localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W        = SAMPLE_W + PTR_W;
  localparam int DIV_CNT_W    = $clog2(SUM_W + 1);

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARE_OFFSET = 1'b0,
    CFG_THRESHOLD   = 1'b1
  } cfg_idx_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV,
    ST_EVAL
  } state_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] raw_pressure;
    logic                       sensor_ready;
    logic                       armed;
    logic                       cooldown_over;
    logic                       other_alarm;
    logic                       alarm_clear;
  } in_beat_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] pressure;
    logic signed [SAMPLE_W-1:0] average;
    logic                       alarm;
    logic                       alarm_raised;
  } out_beat_t;

endpackage

### rtl/pda_ram.sv
module pda_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/pda_div.sv
module pda_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic signed [pda_pkg::SUM_W-1:0] dividend,
  input  logic        [pda_pkg::CNT_W-1:0] divisor,
  output logic                             done,
  output logic signed [pda_pkg::SUM_W-1:0] quotient
);

  logic                             busy_r;
  logic                             done_r;
  logic [pda_pkg::DIV_CNT_W-1:0]    cnt_r;
  logic [pda_pkg::CNT_W-1:0]        rem_r;
  logic [pda_pkg::SUM_W-1:0]        quo_r;
  logic [pda_pkg::CNT_W-1:0]        dvs_r;
  logic                             neg_r;
  logic [pda_pkg::SUM_W-1:0]        mag;
  logic [pda_pkg::CNT_W:0]          trial;
  logic                             fits;

  // Magnitude of the dividend; the quotient sign follows the dividend
  assign mag   = dividend[pda_pkg::SUM_W-1] ? (~dividend + 1'b1) : dividend;
  assign trial = {rem_r, quo_r[pda_pkg::SUM_W-1]};
  assign fits  = (trial >= {1'b0, dvs_r});

  // Control: one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= pda_pkg::DIV_CNT_W'(pda_pkg::SUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == pda_pkg::DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: restoring shift and subtract
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= mag;
      dvs_r <= divisor;
      neg_r <= dividend[pda_pkg::SUM_W-1];
    end else if (busy_r) begin
      rem_r <= fits ? pda_pkg::CNT_W'(trial - {1'b0, dvs_r})
                    : pda_pkg::CNT_W'(trial);
      quo_r <= {quo_r[pda_pkg::SUM_W-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? (~quo_r + 1'b1) : quo_r;

endmodule

### rtl/pressure_deviation_alarm.sv
// An accepted ready sample is registered, then summed into the window, divided by
// the serial divider and evaluated; its result is then registered into the output.
// in_ready is high only in idle, so a new sample is taken only once the last result
// has been loaded; a beat with sensor_ready low gives no result.
// Reset (rst_n, synchronous, active low) clears the sequencer, pointer, fill
// count, running sum, alarm, out_valid, tare, threshold; window not cleared.
module pressure_deviation_alarm (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  pda_pkg::in_beat_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output pda_pkg::out_beat_t                  out_data,
  input  logic                                cfg_we,
  input  logic [pda_pkg::CFG_IDX_W-1:0]       cfg_addr,
  input  logic [pda_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  pda_pkg::state_t                       state_r, state_nxt;
  logic signed [pda_pkg::SAMPLE_W-1:0]   tare_r;
  logic [pda_pkg::SAMPLE_W-1:0]          thresh_r;
  logic [pda_pkg::PTR_W-1:0]             wptr_r, wptr_nxt;
  logic [pda_pkg::CNT_W-1:0]             fill_r, fill_nxt;
  logic signed [pda_pkg::SUM_W-1:0]      sum_r, sum_nxt;
  logic                                  alarm_r;
  logic signed [pda_pkg::SAMPLE_W-1:0]   press_r;
  logic                                  armed_r, cool_r, other_r;
  logic signed [pda_pkg::SAMPLE_W-1:0]   avg_r;
  logic                                  out_valid_r;
  pda_pkg::out_beat_t                    out_data_r;

  logic                                  accept, take;
  logic                                  out_free, out_load;
  logic                                  div_start, div_done;
  logic signed [pda_pkg::SUM_W-1:0]      div_q;
  logic                                  ram_we;
  logic [pda_pkg::SAMPLE_W-1:0]          ram_rdata;
  logic                                  full;
  logic signed [pda_pkg::SAMPLE_W:0]     diff;
  logic signed [pda_pkg::SAMPLE_W-1:0]   press_sat;
  logic signed [pda_pkg::SAMPLE_W:0]     dev;
  logic [pda_pkg::SAMPLE_W:0]            dev_abs;
  logic                                  raise;

  assign accept   = in_valid && in_ready;
  assign take     = accept && in_data.sensor_ready;
  assign out_free = !out_valid_r || out_ready;
  assign full     = (fill_r == pda_pkg::CNT_W'(pda_pkg::WINDOW_DEPTH));

  // Tare and saturate the incoming sample
  always_comb begin
    diff = {in_data.raw_pressure[pda_pkg::SAMPLE_W-1], in_data.raw_pressure}
         - {tare_r[pda_pkg::SAMPLE_W-1], tare_r};
    if (diff[pda_pkg::SAMPLE_W] != diff[pda_pkg::SAMPLE_W-1]) begin
      press_sat = diff[pda_pkg::SAMPLE_W]
                ? {1'b1, {(pda_pkg::SAMPLE_W-1){1'b0}}}
                : {1'b0, {(pda_pkg::SAMPLE_W-1){1'b1}}};
    end else begin
      press_sat = diff[pda_pkg::SAMPLE_W-1:0];
    end
  end

  // Window bookkeeping: drop the oldest entry once full, add the new one
  always_comb begin
    sum_nxt = sum_r
            + pda_pkg::SUM_W'(press_r)
            - (full ? pda_pkg::SUM_W'($signed(ram_rdata)) : '0);
    fill_nxt = full ? fill_r : fill_r + 1'b1;
    wptr_nxt = (wptr_r == pda_pkg::PTR_W'(pda_pkg::WINDOW_DEPTH - 1))
             ? '0 : wptr_r + 1'b1;
  end

  // Deviation compare
  always_comb begin
    dev     = {press_r[pda_pkg::SAMPLE_W-1], press_r}
            - {avg_r[pda_pkg::SAMPLE_W-1], avg_r};
    dev_abs = dev[pda_pkg::SAMPLE_W] ? (~dev + 1'b1) : dev;
    raise   = armed_r && !alarm_r && !other_r && cool_r && full
            && (dev_abs > {1'b0, thresh_r});
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pda_pkg::ST_IDLE: begin
        if (take) state_nxt = pda_pkg::ST_SUM;
      end
      pda_pkg::ST_SUM: begin
        state_nxt = pda_pkg::ST_DIV;
      end
      pda_pkg::ST_DIV: begin
        if (div_done) state_nxt = pda_pkg::ST_EVAL;
      end
      pda_pkg::ST_EVAL: begin
        if (out_free) state_nxt = pda_pkg::ST_IDLE;
      end
      default: state_nxt = pda_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    ram_we    = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      pda_pkg::ST_IDLE: in_ready = 1'b1;
      pda_pkg::ST_SUM: begin
        div_start = 1'b1;
        ram_we    = 1'b1;
      end
      pda_pkg::ST_DIV: ;
      pda_pkg::ST_EVAL: out_load = out_free;
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pda_pkg::ST_IDLE;
      wptr_r      <= '0;
      fill_r      <= '0;
      sum_r       <= '0;
      alarm_r     <= 1'b0;
      out_valid_r <= 1'b0;
      tare_r      <= '0;
      thresh_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (ram_we) begin
        wptr_r <= wptr_nxt;
        fill_r <= fill_nxt;
        sum_r  <= sum_nxt;
      end
      // Clear on request at acceptance, latch on a raising evaluation
      if (accept && in_data.alarm_clear) begin
        alarm_r <= 1'b0;
      end else if (out_load && raise) begin
        alarm_r <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_addr)
          pda_pkg::CFG_TARE_OFFSET: tare_r   <= cfg_wdata;
          pda_pkg::CFG_THRESHOLD:   thresh_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (take) begin
      press_r <= press_sat;
      armed_r <= in_data.armed;
      cool_r  <= in_data.cooldown_over;
      other_r <= in_data.other_alarm;
    end
    if (div_done) begin
      avg_r <= div_q[pda_pkg::SAMPLE_W-1:0];
    end
    if (out_load) begin
      out_data_r.pressure     <= press_r;
      out_data_r.average      <= avg_r;
      out_data_r.alarm        <= alarm_r || raise;
      out_data_r.alarm_raised <= raise;
    end
  end

  pda_ram #(
    .WIDTH (pda_pkg::SAMPLE_W),
    .DEPTH (pda_pkg::WINDOW_DEPTH)
  ) u_window (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wptr_r),
    .wdata (press_r),
    .re    (take),
    .raddr (wptr_r),
    .rdata (ram_rdata)
  );

  pda_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_nxt),
    .divisor  (fill_nxt),
    .done     (div_done),
    .quotient (div_q)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Fill count never passes the window depth
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= pda_pkg::CNT_W'(pda_pkg::WINDOW_DEPTH))
    else $error("fill count beyond window depth");

  // Divider finishes only while the sequencer waits for it
  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == pda_pkg::ST_DIV))
    else $error("divider done outside divide state");

  // A clear request leaves the alarm low on the next cycle
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.alarm_clear) |=> !alarm_r)
    else $error("alarm not cleared");

  // A raised alarm is reported as set
  a_raised_set: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.alarm_raised) |-> out_data_r.alarm)
    else $error("raised without alarm");

endmodule
